[design/dptt_pkg.sv]
// ---------------------------------------------------------------------------
// dptt_pkg: shared types and codes of the depth-preferred transposition table
//
// Request and response payloads, operation and bound codes, and the score
// value that stands for an unknown result.
// ---------------------------------------------------------------------------
package dptt_pkg;

   // Operation codes of a request.
   typedef logic [1:0] op_type;
   localparam op_type OP_SAVE  = 2'd0;
   localparam op_type OP_PROBE = 2'd1;
   localparam op_type OP_MOVE  = 2'd2;

   // Bound kinds of a stored score.
   typedef logic [1:0] bound_type;
   localparam bound_type BOUND_EXACT = 2'd0;
   localparam bound_type BOUND_UPPER = 2'd1;
   localparam bound_type BOUND_LOWER = 2'd2;

   typedef logic signed [15:0] score_type;

   // Score that marks an empty or failed probe.
   localparam score_type SCORE_UNKNOWN = -16'sd32767;

   // One request item.
   typedef struct packed {
      op_type      operation;
      logic [63:0] key;
      logic [7:0]  depth;
      score_type   score;
      bound_type   bound_kind;
      logic [15:0] move_code;
      score_type   alpha;
      score_type   beta;
   } req_type;

   // One response item.
   typedef struct packed {
      score_type   probe_value;
      logic [15:0] stored_move;
   } rsp_type;

endpackage

[design/dptt_stream_if.sv]
// ---------------------------------------------------------------------------
// dptt_stream_if: valid/ready channel
//
// Carries one payload item per transfer. A transfer happens at a rising
// clock edge with valid and ready both high.
// ---------------------------------------------------------------------------
interface dptt_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[design/dptt_ram.sv]
// ---------------------------------------------------------------------------
// dptt_ram: generic single-port-write, single-port-read synchronous RAM
//
// One write and one read per cycle. The read data is registered and shows
// the old contents when the read and the write hit the same address.
// ---------------------------------------------------------------------------
module dptt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read (read-first on a collision).
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/depth_preferred_transposition_table_unit.sv]
// ---------------------------------------------------------------------------
// depth_preferred_transposition_table_unit: direct-mapped search cache
//
//   Channel   Direction  Payload     Transfer
//   req_ch    in         req_type    save, probe or move read
//   rsp_ch    out        rsp_type    probe answer or stored move
//
// One item per cycle through a two-stage read-modify-write pipeline around
// one table RAM: stage 1, then the response register.
// A save to the slot that the next item reads is forwarded into stage 1.
// After reset a clearing pass writes every slot while req_ch.ready stays
// low. A waiting response holds stage 1, and with it the input, only for
// probes and move reads; saves pass through.
// ---------------------------------------------------------------------------
module depth_preferred_transposition_table_unit #(
   parameter int TABLE_ENTRIES = 4096,
   parameter int MOVE_BITS     = 16
) (
   input logic          clock,
   input logic          reset,
   dptt_stream_if.sink   req_ch,
   dptt_stream_if.source rsp_ch
);
   import dptt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   // One table slot.
   typedef struct packed {
      logic [63:0]          key;
      logic [7:0]           depth;
      score_type            score;
      bound_type            bound;
      logic [MOVE_BITS-1:0] move;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      key:   64'd0,
      depth: 8'd0,
      score: SCORE_UNKNOWN,
      bound: BOUND_EXACT,
      move:  '0
   };

   // Clearing pass state.
   logic             clr_active_ff, clr_active_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;

   // Stage 1 state.
   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_req_ff;
   logic      fwd_hit_ff;
   entry_type fwd_data_ff;

   // Response register.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic             req_fire;
   logic             s1_has_rsp;
   logic             s1_fire;
   logic             out_free;
   logic [IDX_W-1:0] s1_idx;
   logic [IDX_W-1:0] req_idx;
   entry_type        rd_entry;
   entry_type        cur_entry;
   entry_type        save_entry;
   logic             key_match;
   logic             save_write;
   logic             probe_hit;
   score_type        probe_ans;
   rsp_type          rsp_next;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;

   // Handshake and pipeline advance.
   assign req_idx      = req_ch.data.key[IDX_W-1:0];
   assign s1_idx       = s1_req_ff.key[IDX_W-1:0];
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign s1_has_rsp   = (s1_req_ff.operation == OP_PROBE) ||
                         (s1_req_ff.operation == OP_MOVE);
   assign s1_fire      = s1_valid_ff && (!s1_has_rsp || out_free);
   assign req_ch.ready = !clr_active_ff && (!s1_valid_ff || s1_fire);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Slot contents seen by stage 1, with the last write forwarded.
   assign cur_entry = fwd_hit_ff ? fwd_data_ff : rd_entry;
   assign key_match = (cur_entry.key == s1_req_ff.key);

   // Depth-preferred replacement on save.
   assign save_write = (s1_req_ff.operation == OP_SAVE) &&
                       (!key_match || (s1_req_ff.depth >= cur_entry.depth));

   always_comb begin
      save_entry       = ENTRY_RESET;
      save_entry.key   = s1_req_ff.key;
      save_entry.depth = s1_req_ff.depth;
      save_entry.score = s1_req_ff.score;
      save_entry.bound = s1_req_ff.bound_kind;
      save_entry.move  = MOVE_BITS'(s1_req_ff.move_code);
   end

   // Probe answer from the stored bound.
   assign probe_hit = key_match && (cur_entry.depth >= s1_req_ff.depth);

   always_comb begin
      probe_ans = SCORE_UNKNOWN;
      if (probe_hit) begin
         case (cur_entry.bound)
            BOUND_EXACT: begin
               probe_ans = cur_entry.score;
            end
            BOUND_UPPER: begin
               if (cur_entry.score <= s1_req_ff.alpha) begin
                  probe_ans = s1_req_ff.alpha;
               end
            end
            BOUND_LOWER: begin
               if (cur_entry.score >= s1_req_ff.beta) begin
                  probe_ans = s1_req_ff.beta;
               end
            end
            default: begin
               probe_ans = SCORE_UNKNOWN;
            end
         endcase
      end
   end

   // Response payload.
   always_comb begin
      rsp_next.probe_value = 16'sd0;
      rsp_next.stored_move = 16'd0;
      case (s1_req_ff.operation)
         OP_PROBE: begin
            rsp_next.probe_value = probe_ans;
         end
         OP_MOVE: begin
            rsp_next.stored_move = 16'(cur_entry.move);
         end
         default: begin
            rsp_next.probe_value = 16'sd0;
         end
      endcase
   end

   // RAM write port: clearing pass or stage 1 write-back.
   always_comb begin
      if (clr_active_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_idx_ff;
         ram_wr_data = ENTRY_RESET;
      end else begin
         ram_wr_en   = s1_fire && save_write;
         ram_wr_addr = s1_idx;
         ram_wr_data = save_entry;
      end
   end

   dptt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_idx),
      .rd_data (rd_entry)
   );

   // Next values of control state.
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_idx_in    = clr_idx_ff;
      if (clr_active_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
            clr_active_in = 1'b0;
         end
      end

      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_fire && s1_has_rsp) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
         // The forwarded entry lives only as long as the stage 1 item it serves.
         if (req_fire) begin
            fwd_hit_ff <= s1_fire && save_write && (s1_idx == req_idx);
         end else if (s1_fire) begin
            fwd_hit_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff   <= req_ch.data;
         fwd_data_ff <= save_entry;
      end
      if (s1_fire && s1_has_rsp) begin
         out_data_ff <= rsp_next;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_data_ff;

`ifndef NO_ASSERTIONS
   // No request enters the pipeline during the clearing pass.
   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !s1_valid_ff && !req_fire)
      else $error("request in pipeline during clearing pass");

   // A forwarded entry only ever belongs to an item held in stage 1.
   a_fwd_needs_item: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> s1_valid_ff)
      else $error("forwarded entry without stage 1 item");

   // A response never overwrites one that is still waiting.
   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_has_rsp) |-> out_free)
      else $error("response register overwritten");

   // A stage 1 item that cannot deliver its response stays in place.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_has_rsp && !out_free) |=> s1_valid_ff && $stable(s1_req_ff))
      else $error("stage 1 item lost under stall");
`endif

endmodule

[tb/sv/tb_depth_preferred_transposition_table_unit.sv]
// ---------------------------------------------------------------------------
// tb_depth_preferred_transposition_table_unit: self-checking bench
//
// Drives saves, probes and move reads into the table through the request
// channel and checks every response against a mirror of the slot store
// kept here. A directed opening covers field extremes, the replacement
// rule and each bound kind. It is followed by random save-then-probe
// sequences over a few crowded slots, mixed with noise. Both channels
// idle at random, and the receiver makes one long hold-off to back the
// block up.
// ---------------------------------------------------------------------------
module tb_depth_preferred_transposition_table_unit;
   import dptt_pkg::*;

   localparam int ENTRIES      = 4096;
   localparam int INDEX_BITS   = 12;
   localparam int RANDOM_ITEMS = 600;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AFTER   = 120;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 250000;

   // Codes that the package leaves unnamed.
   localparam op_type    OP_IDLE      = 2'd3;
   localparam bound_type BOUND_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;

   dptt_stream_if #(.payload_type(req_type)) req_if ();
   dptt_stream_if #(.payload_type(rsp_type)) rsp_if ();

   depth_preferred_transposition_table_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Mirror of the slot store.
   logic [63:0] mirror_key   [ENTRIES];
   logic [7:0]  mirror_depth [ENTRIES];
   score_type   mirror_score [ENTRIES];
   bound_type   mirror_bound [ENTRIES];
   logic [15:0] mirror_move  [ENTRIES];

   req_type     pending_requests [$];
   rsp_type     expected_answers [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Driver and receiver pacing state.
   int unsigned send_gap    = 0;
   int unsigned send_tick   = 0;
   bit          send_calm   = 1'b0;
   int unsigned recv_stall  = 0;
   int unsigned recv_tick   = 0;
   int unsigned recv_seen   = 0;
   bit          recv_calm   = 1'b0;
   bit          hold_done   = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror update for one accepted request; queues the answer it causes.
   function automatic void apply_request(req_type r);
      int unsigned idx;
      score_type   answer;
      idx = int'(r.key[INDEX_BITS-1:0]);
      case (r.operation)
         OP_SAVE: begin
            if (mirror_key[idx] != r.key || r.depth >= mirror_depth[idx]) begin
               mirror_key[idx]   = r.key;
               mirror_depth[idx] = r.depth;
               mirror_score[idx] = r.score;
               mirror_bound[idx] = r.bound_kind;
               mirror_move[idx]  = r.move_code;
            end
         end
         OP_PROBE: begin
            answer = SCORE_UNKNOWN;
            if (mirror_key[idx] == r.key && mirror_depth[idx] >= r.depth) begin
               if (mirror_bound[idx] == BOUND_EXACT)
                  answer = mirror_score[idx];
               else if (mirror_bound[idx] == BOUND_UPPER && mirror_score[idx] <= r.alpha)
                  answer = r.alpha;
               else if (mirror_bound[idx] == BOUND_LOWER && mirror_score[idx] >= r.beta)
                  answer = r.beta;
            end
            expected_answers.push_back('{probe_value: answer, stored_move: 16'd0});
         end
         OP_MOVE: begin
            expected_answers.push_back('{probe_value: score_type'(0),
                                         stored_move: mirror_move[idx]});
         end
         default: begin
            // Operation three is dropped by the block.
         end
      endcase
   endfunction

   function automatic req_type make_request(op_type op, logic [63:0] key, int depth,
                                            int score, bound_type bound,
                                            logic [15:0] move, int alpha, int beta);
      req_type r;
      r.operation  = op;
      r.key        = key;
      r.depth      = depth[7:0];
      r.score      = score_type'(score);
      r.bound_kind = bound;
      r.move_code  = move;
      r.alpha      = score_type'(alpha);
      r.beta       = score_type'(beta);
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.operation  = op_type'($urandom_range(0, 3));
      r.key        = {$urandom(), $urandom()};
      r.depth      = 8'($urandom());
      r.score      = score_type'($urandom());
      r.bound_kind = bound_type'($urandom_range(0, 3));
      r.move_code  = 16'($urandom());
      r.alpha      = score_type'($urandom());
      r.beta       = score_type'($urandom());
      return r;
   endfunction

   // A window limit a few points away from a stored score.
   function automatic score_type near_score(score_type s);
      int v;
      v = int'(s) + int'($urandom_range(0, 6)) - 3;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return score_type'(v);
   endfunction

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int unsigned draw_gap(bit calm);
      if (calm || $urandom_range(0, 3) != 0)
         return 0;
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Request driver: offers queued items and updates the mirror on each transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         send_tick++;
         if (send_tick % 64 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
         if (!req_if.valid || req_if.ready) begin
            if (req_if.valid)
               apply_request(req_if.data);
            if (send_gap > 0) begin
               req_if.valid <= 1'b0;
               send_gap--;
            end else if (pending_requests.size() > 0) begin
               req_if.data  <= pending_requests.pop_front();
               req_if.valid <= 1'b1;
               send_gap = draw_gap(send_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready: random stalls plus one long hold-off to fill the pipeline.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         recv_tick++;
         if (recv_tick % 64 == 0)
            recv_calm = ($urandom_range(0, 3) == 0);
         if (rsp_if.valid && rsp_if.ready)
            recv_seen++;
         if (!hold_done && recv_seen >= HOLD_AFTER) begin
            recv_stall = LONG_HOLD;
            hold_done  = 1'b1;
         end
         if (recv_stall > 0) begin
            rsp_if.ready <= 1'b0;
            recv_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            recv_stall = draw_gap(recv_calm);
         end
      end
   end

   // Response monitor: each transfer is checked against the oldest expected answer.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_answers.size() == 0) begin
            $error("unexpected response: probe_value %0d, stored_move 0x%04h",
                   rsp_if.data.probe_value, rsp_if.data.stored_move);
            error_count++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_if.data.probe_value !== want.probe_value) begin
               $error("probe_value: expected %0d, got %0d",
                      want.probe_value, rsp_if.data.probe_value);
               error_count++;
            end
            if (rsp_if.data.stored_move !== want.stored_move) begin
               $error("stored_move: expected 0x%04h, got 0x%04h",
                      want.stored_move, rsp_if.data.stored_move);
               error_count++;
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      logic [63:0] key_pool [16];
      logic [INDEX_BITS-1:0] crowded_slot [4];
      logic [63:0] k1, k2, k3, k4;
      req_type     item;
      req_type     follow;
      int          random_count;
      int          pick;
      int          base_depth;
      int          near_depth;
      int          choice;

      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;

      // Mirror starts as the cleared store.
      for (int i = 0; i < ENTRIES; i++) begin
         mirror_key[i]   = '0;
         mirror_depth[i] = '0;
         mirror_score[i] = SCORE_UNKNOWN;
         mirror_bound[i] = BOUND_EXACT;
         mirror_move[i]  = '0;
      end

      // Directed opening: cleared slot, extremes, replacement rule, every bound kind.
      k1 = '1;
      k2 = 64'h0123_4567_89AB_CFFF;
      k3 = 64'hA5A5_0000_1234_55A5;
      k4 = 64'h8000_0000_0000_0123;
      pending_requests.push_back(make_request(OP_PROBE, '0, 0, 0, BOUND_EXACT, 0, 0, 0));
      pending_requests.push_back(make_request(OP_PROBE, '0, 255, 0, BOUND_EXACT, 0, 0, 0));
      pending_requests.push_back(make_request(OP_MOVE, '0, 0, 0, BOUND_EXACT, 0, 0, 0));
      pending_requests.push_back(make_request(OP_SAVE, k1, 255, 32767, BOUND_EXACT,
                                              16'hFFFF, 0, 0));
      pending_requests.push_back(make_request(OP_PROBE, k1, 255, 0, BOUND_EXACT, 0, 0, 0));
      pending_requests.push_back(make_request(OP_MOVE, k1, 0, 0, BOUND_EXACT, 0, 0, 0));
      // Same key with a shallower depth must not replace the slot.
      pending_requests.push_back(make_request(OP_SAVE, k1, 10, 5, BOUND_EXACT,
                                              16'h0055, 0, 0));
      pending_requests.push_back(make_request(OP_PROBE, k1, 0, 0, BOUND_EXACT, 0, 0, 0));
      pending_requests.push_back(make_request(OP_MOVE, k1, 0, 0, BOUND_EXACT, 0, 0, 0));
      // Equal depth replaces; most negative score with an upper bound.
      pending_requests.push_back(make_request(OP_SAVE, k1, 255, -32768, BOUND_UPPER,
                                              16'h1234, 0, 0));
      pending_requests.push_back(make_request(OP_PROBE, k1, 255, 0, BOUND_EXACT, 0,
                                              -32768, 0));
      pending_requests.push_back(make_request(OP_PROBE, k1, 255, 0, BOUND_EXACT, 0,
                                              32767, -32768));
      // A different key in the same slot evicts even at depth zero.
      pending_requests.push_back(make_request(OP_SAVE, k2, 0, 100, BOUND_LOWER,
                                              16'h00AA, 0, 0));
      pending_requests.push_back(make_request(OP_PROBE, k2, 0, 0, BOUND_EXACT, 0, 0, 100));
      pending_requests.push_back(make_request(OP_PROBE, k2, 0, 0, BOUND_EXACT, 0, 0, 101));
      pending_requests.push_back(make_request(OP_PROBE, k2, 0, 0, BOUND_EXACT, 0, 0,
                                              -32768));
      pending_requests.push_back(make_request(OP_PROBE, k1, 0, 0, BOUND_EXACT, 0, 0, 0));
      // Upper bound: alpha at and below the stored score, then a deeper probe.
      pending_requests.push_back(make_request(OP_SAVE, k3, 7, -50, BOUND_UPPER,
                                              16'h8001, 0, 0));
      pending_requests.push_back(make_request(OP_PROBE, k3, 7, 0, BOUND_EXACT, 0, -50, 0));
      pending_requests.push_back(make_request(OP_PROBE, k3, 7, 0, BOUND_EXACT, 0, -51, 0));
      pending_requests.push_back(make_request(OP_PROBE, k3, 8, 0, BOUND_EXACT, 0, 0, 0));
      // Bound kind three is stored but never answers; operation three is dropped.
      pending_requests.push_back(make_request(OP_SAVE, k4, 3, 0, BOUND_UNUSED,
                                              16'h7E7E, 0, 0));
      pending_requests.push_back(make_request(OP_PROBE, k4, 0, 0, BOUND_EXACT, 0, 0, 0));
      pending_requests.push_back(make_request(OP_IDLE, k4, 255, 1, BOUND_EXACT,
                                              16'hFFFF, 0, 0));
      pending_requests.push_back(make_request(OP_MOVE, k4, 0, 0, BOUND_EXACT, 0, 0, 0));

      // Key pool crowded into four slots so that keys compete for the same entry.
      for (int i = 0; i < 4; i++)
         crowded_slot[i] = INDEX_BITS'($urandom());
      for (int i = 0; i < 16; i++) begin
         key_pool[i] = {$urandom(), $urandom()};
         key_pool[i][INDEX_BITS-1:0] = crowded_slot[i % 4];
      end

      // Random part: mostly a save followed by probes near its depth and score.
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         item = random_request();
         item.key = key_pool[$urandom_range(0, 15)];
         if (pick < 7) begin
            base_depth      = $urandom_range(0, 255);
            item.operation  = OP_SAVE;
            item.depth      = base_depth[7:0];
            item.bound_kind = ($urandom_range(0, 15) == 0) ? BOUND_UNUSED
                                                           : bound_type'($urandom_range(0, 2));
            pending_requests.push_back(item);
            random_count++;
            repeat ($urandom_range(1, 3)) begin
               follow     = random_request();
               follow.key = item.key;
               near_depth = base_depth + int'($urandom_range(0, 4)) - 2;
               if (near_depth < 0)
                  near_depth = 0;
               if (near_depth > 255)
                  near_depth = 255;
               follow.depth = near_depth[7:0];
               choice = $urandom_range(0, 5);
               if (choice == 0)
                  follow.operation = OP_SAVE;
               else if (choice == 1)
                  follow.operation = OP_MOVE;
               else
                  follow.operation = OP_PROBE;
               follow.alpha = near_score(item.score);
               follow.beta  = near_score(item.score);
               pending_requests.push_back(follow);
               random_count++;
            end
         end else if (pick == 7) begin
            item.operation = OP_PROBE;
            pending_requests.push_back(item);
            random_count++;
         end else if (pick == 8) begin
            item.operation = OP_MOVE;
            if ($urandom_range(0, 1) == 0)
               item.key = {$urandom(), $urandom()};
            pending_requests.push_back(item);
            random_count++;
         end else begin
            // Noise: every field random, operation three included.
            item.key = {$urandom(), $urandom()};
            pending_requests.push_back(item);
            if (item.operation != OP_IDLE)
               random_count++;
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last transfer, then for the last response.
      do @(posedge clock); while (pending_requests.size() > 0 || req_if.valid);
      do @(posedge clock); while (expected_answers.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
